@@ rtl/analog_approach_qualifier_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef ANALOG_APPROACH_QUALIFIER_UNIT_ASSERT_SVH
`define ANALOG_APPROACH_QUALIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AAQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define AAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/aaq_pkg.sv @@
package aaq_pkg;

	localparam int LANES        = 3;
	localparam int CHANNELS_DEF = 3;
	localparam int SAMPLE_W     = 10;
	localparam int TIME_W       = 32;
	localparam int DUR_W        = 16;
	localparam int MODE_W       = 3;
	localparam int REG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int S_TDATA_W    = 64;
	localparam int M_TDATA_W    = 16;

	localparam logic [11:0] BLOCK_MARGIN = 12'd20;

	typedef enum logic [MODE_W-1:0] {
		MODE_UNKNOWN  = 3'd0,
		MODE_REST     = 3'd1,
		MODE_APPROACH = 3'd2,
		MODE_ACTIVE   = 3'd3,
		MODE_BLOCKED  = 3'd4
	} mode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_REST_CENTER   = 3'd0,
		REG_REST_TOL      = 3'd1,
		REG_ACT_LIMIT     = 3'd2,
		REG_REBOUND_TOL   = 3'd3,
		REG_SETTLE_TIME   = 3'd4,
		REG_CONFIRM_TIME  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] rest_center;
		logic [SAMPLE_W-1:0] rest_tolerance;
		logic [SAMPLE_W-1:0] activation_limit;
		logic [SAMPLE_W-1:0] rebound_tolerance;
		logic [DUR_W-1:0]    settle_time;
		logic [DUR_W-1:0]    confirm_time;
	} cfg_t;

	localparam logic [SAMPLE_W-1:0] RST_REST_CENTER  = 10'd510;
	localparam logic [SAMPLE_W-1:0] RST_REST_TOL     = 10'd15;
	localparam logic [SAMPLE_W-1:0] RST_ACT_LIMIT    = 10'd450;
	localparam logic [SAMPLE_W-1:0] RST_REBOUND_TOL  = 10'd45;
	localparam logic [DUR_W-1:0]    RST_SETTLE_TIME  = 16'd500;
	localparam logic [DUR_W-1:0]    RST_CONFIRM_TIME = 16'd200;

endpackage

@@ rtl/aaq_channel.sv @@
// One channel qualifier: state registers plus the next-state logic.
module aaq_channel
	import aaq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [TIME_W-1:0]   now_ms,
	input  cfg_t                cfg,
	output mode_t               mode_nx
);

	mode_t               mode_q;
	logic                timing_q;
	logic [SAMPLE_W-1:0] low_q;
	logic [TIME_W-1:0]   drop_q;
	logic [TIME_W-1:0]   start_q;

	logic                timing_nx;
	logic [SAMPLE_W-1:0] low_nx;
	logic [TIME_W-1:0]   drop_nx;
	logic [TIME_W-1:0]   start_nx;

	always_comb begin
		logic [SAMPLE_W:0]   band_hi;
		logic                below;
		logic                in_band;
		logic                over_margin;
		logic [SAMPLE_W:0]   min_hi;
		logic [SAMPLE_W:0]   act_hi;
		mode_t               cur;

		band_hi     = {1'b0, cfg.rest_center} + {1'b0, cfg.rest_tolerance};
		below       = ({1'b0, sample} + {1'b0, cfg.rest_tolerance}) < {1'b0, cfg.rest_center};
		in_band     = !below && ({1'b0, sample} <= band_hi);
		over_margin = {2'b00, sample} > ({1'b0, band_hi} + BLOCK_MARGIN);
		min_hi      = {1'b0, low_q} + {1'b0, cfg.rebound_tolerance};
		act_hi      = {1'b0, cfg.activation_limit} + {1'b0, cfg.rebound_tolerance};

		cur       = mode_q;
		timing_nx = timing_q;
		low_nx    = low_q;
		drop_nx   = drop_q;
		start_nx  = start_q;

		// rising far past the band while approaching blocks first
		if (mode_q == MODE_APPROACH && over_margin) begin
			cur       = MODE_BLOCKED;
			timing_nx = 1'b0;
		end
		mode_nx = cur;

		case (cur)
			MODE_REST: begin
				if (below) begin
					mode_nx = MODE_APPROACH;
					low_nx  = sample;
					drop_nx = now_ms;
				end
			end
			MODE_APPROACH: begin
				if ({1'b0, sample} > min_hi) begin
					mode_nx   = MODE_BLOCKED;
					timing_nx = 1'b0;
				end else begin
					if (sample < low_q) begin
						low_nx  = sample;
						drop_nx = now_ms;
					end
					if (sample <= cfg.activation_limit &&
					    (now_ms - drop_nx) >= {16'd0, cfg.confirm_time})
						mode_nx = MODE_ACTIVE;
				end
			end
			MODE_ACTIVE: begin
				if ({1'b0, sample} > act_hi) begin
					mode_nx   = MODE_UNKNOWN;
					timing_nx = 1'b0;
				end
			end
			default: begin
				// unknown and blocked: wait for the band to settle
				if (in_band) begin
					if (!timing_nx) begin
						timing_nx = 1'b1;
						start_nx  = now_ms;
					end
					if ((now_ms - start_nx) >= {16'd0, cfg.settle_time})
						mode_nx = MODE_REST;
				end else begin
					timing_nx = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_UNKNOWN;
			timing_q <= 1'b0;
		end else if (upd) begin
			mode_q   <= mode_nx;
			timing_q <= timing_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			low_q   <= low_nx;
			drop_q  <= drop_nx;
			start_q <= start_nx;
		end
	end

endmodule

@@ rtl/analog_approach_qualifier_unit.sv @@
// Analog approach qualifier.
// Input stream (s_tvalid/s_tready/s_tdata): one word per scan, holding three
// 10-bit sensor samples and a wrapping 32-bit millisecond timestamp.
// Output stream (m_tvalid/m_tready/m_tdata): one word per input word, with
// the state of each channel (unknown, rest, approaching, active, blocked)
// and a flag set when every processed channel is active.
// Configuration: cfg_we/cfg_idx/cfg_data write the six thresholds and
// durations; write only while no scan is in flight.
// A word accepted into the input register moves on to the result register,
// which drives m_tdata. Throughput: one word per cycle while m_tready is
// high; the per-channel update is one compare-and-select pass between
// the single input register and the result register.
// Reset: all channels return to unknown, settle timers stop, config
// registers take their default values, both pipeline stages empty.
// Stall: when m_tready is low the result word holds; one more word can
// sit in the input stage, after which s_tready drops until the sink
// takes the result.
module analog_approach_qualifier_unit
	import aaq_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [9:0] sample_a, [19:10] sample_b, [29:20] sample_c, [61:30] now_ms, [63:62] zero
	input  logic [S_TDATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [2:0] mode_a, [5:3] mode_b, [8:6] mode_c, [9] all_active, [15:10] zero
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// only three samples arrive, so at most three channels run
	localparam int NCH = (CHANNELS < LANES) ? CHANNELS : LANES;

	cfg_t cfg_q;

	// input stage
	logic                valid_s1;
	logic [SAMPLE_W-1:0] smp_s1 [LANES];
	logic [TIME_W-1:0]   now_s1;

	// result stage
	logic                valid_s2;
	mode_t               mode_s2 [LANES];
	logic                all_s2;

	logic  out_free;
	logic  adv;
	mode_t mode_nx [LANES];
	logic  all_nx;

	assign out_free = !valid_s2 || m_tready;
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// config registers, written by index; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rest_center       <= RST_REST_CENTER;
			cfg_q.rest_tolerance    <= RST_REST_TOL;
			cfg_q.activation_limit  <= RST_ACT_LIMIT;
			cfg_q.rebound_tolerance <= RST_REBOUND_TOL;
			cfg_q.settle_time       <= RST_SETTLE_TIME;
			cfg_q.confirm_time      <= RST_CONFIRM_TIME;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_REST_CENTER:  cfg_q.rest_center       <= cfg_data[SAMPLE_W-1:0];
				REG_REST_TOL:     cfg_q.rest_tolerance    <= cfg_data[SAMPLE_W-1:0];
				REG_ACT_LIMIT:    cfg_q.activation_limit  <= cfg_data[SAMPLE_W-1:0];
				REG_REBOUND_TOL:  cfg_q.rebound_tolerance <= cfg_data[SAMPLE_W-1:0];
				REG_SETTLE_TIME:  cfg_q.settle_time       <= cfg_data[DUR_W-1:0];
				REG_CONFIRM_TIME: cfg_q.confirm_time      <= cfg_data[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			for (int k = 0; k < LANES; k++)
				smp_s1[k] <= s_tdata[k*SAMPLE_W +: SAMPLE_W];
			now_s1 <= s_tdata[LANES*SAMPLE_W +: TIME_W];
		end
	end

	// channel qualifiers; state advances when the scan moves to the result stage
	for (genvar k = 0; k < LANES; k++) begin : g_lane
		if (k < NCH) begin : g_run
			aaq_channel u_chan (
				.clk     (clk),
				.arst_n  (arst_n),
				.upd     (adv),
				.sample  (smp_s1[k]),
				.now_ms  (now_s1),
				.cfg     (cfg_q),
				.mode_nx (mode_nx[k])
			);
		end else begin : g_off
			assign mode_nx[k] = MODE_UNKNOWN;
		end
	end

	always_comb begin
		all_nx = 1'b1;
		for (int k = 0; k < NCH; k++)
			if (mode_nx[k] != MODE_ACTIVE)
				all_nx = 1'b0;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < LANES; k++)
				mode_s2[k] <= mode_nx[k];
			all_s2 <= all_nx;
		end
	end

	assign m_tvalid = valid_s2;

	always_comb begin
		m_tdata = '0;
		for (int k = 0; k < LANES; k++)
			m_tdata[k*MODE_W +: MODE_W] = mode_s2[k];
		m_tdata[LANES*MODE_W] = all_s2;
	end

endmodule

@@ rtl/aaq_checker.sv @@
`include "analog_approach_qualifier_unit_assert.svh"

// Port-level checks on the qualifier.
module aaq_checker
	import aaq_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [M_TDATA_W-1:0]  m_tdata
);

	logic all_flag;
	logic [MODE_W-1:0] mode_a;

	assign all_flag = m_tdata[LANES*MODE_W];
	assign mode_a   = m_tdata[MODE_W-1:0];

	`AAQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")
	`AAQ_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata), "result word changed while stalled")
	// the input side only backs up when a result word is waiting
	`AAQ_ASSERT_NOW(a_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready, "input stalled without a waiting result")
	// the first channel runs whenever CHANNELS is at least one, so the flag needs it active
	`AAQ_ASSERT_NOW(a_all_flag, clk, arst_n, m_tvalid && all_flag, mode_a == MODE_ACTIVE, "all-active flag with first channel not active")

endmodule

bind analog_approach_qualifier_unit aaq_checker u_aaq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
